### design/bnd_pkg.sv
// types, constants and the crc step shared by the stream deframer
package bnd_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_INITIAL = 8'd3;

	localparam logic [7:0]  PREAMBLE_RST   = 8'h55;
	localparam logic [7:0]  START_CHAR_RST = 8'h24;
	localparam logic [15:0] CRC_POLY_RST   = 16'h1021;
	localparam logic [15:0] CRC_INIT_RST   = 16'h1D0F;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic [2:0] PEV_NONE    = 3'd0;
	localparam logic [2:0] PEV_TYPE    = 3'd1;
	localparam logic [2:0] PEV_LENGTH  = 3'd2;
	localparam logic [2:0] PEV_PAYLOAD = 3'd3;
	localparam logic [2:0] PEV_CRC_HI  = 3'd4;
	localparam logic [2:0] PEV_GOOD    = 3'd5;
	localparam logic [2:0] PEV_BAD     = 3'd6;

	localparam logic [2:0] SEV_NONE   = 3'd0;
	localparam logic [2:0] SEV_HEADER = 3'd1;
	localparam logic [2:0] SEV_BYTE   = 3'd2;
	localparam logic [2:0] SEV_END    = 3'd3;
	localparam logic [2:0] SEV_ABORT  = 3'd4;

	localparam int NUM_PKT_TYPES = 5;
	localparam int NUM_TALKERS = 14;

	localparam logic [15:0] PKT_TYPES [NUM_PKT_TYPES] = '{
		"s1", "gN", "iN", "d1", "sT"
	};

	localparam logic [39:0] TALKERS [NUM_TALKERS] = '{
		"GPGGA", "GPRMC", "GPGSV", "GLGSV", "GAGSV", "BDGSV", "GPGSA",
		"GLGSA", "GAGSA", "BDGSA", "GPZDA", "GPVTG", "PASHR", "GNINS"
	};

	typedef enum logic [3:0] {
		H_SYNC0 = 4'b0001,
		H_SYNC1 = 4'b0010,
		H_TYPE1 = 4'b0100,
		H_TYPE2 = 4'b1000
	} hunt_t;

	typedef enum logic [2:0] {
		SM_IDLE = 3'b001,
		SM_HEAD = 3'b010,
		SM_BODY = 3'b100
	} smode_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
			input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/bnd_ifs.sv
// channel interfaces of the stream deframer
interface bnd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bnd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [2:0] packet_event;
	logic [2:0] packet_kind;
	logic [7:0] payload_length;
	logic [7:0] payload_index;
	logic [2:0] sentence_event;
	logic [3:0] sentence_kind;
	modport source (output valid, output data_byte, output packet_event,
		output packet_kind, output payload_length, output payload_index,
		output sentence_event, output sentence_kind, input ready);
	modport sink (input valid, input data_byte, input packet_event,
		input packet_kind, input payload_length, input payload_index,
		input sentence_event, input sentence_kind, output ready);
endinterface

interface bnd_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/binary_and_nmea_stream_deframer.sv
// Tags each received byte for a binary frame parser (preamble, type, length,
// payload, crc-16) and an nmea sentence detector. One word goes in and one word
// comes out per byte; a new byte is taken every clock cycle while the output is
// not stalled by tx.ready. Each byte passes an input register, then one pass of
// framer logic (header compares and an 8-step crc update) into the output
// register. The crc of the first type character is precomputed when it arrives,
// so each cycle feeds at most one byte through the crc. Configuration writes take
// effect at once and are always accepted.
module binary_and_nmea_stream_deframer
	import bnd_pkg::*;
#(
	parameter int SENTENCE_MAX_LEN = 256
) (
	input  logic clk,
	input  logic arst_n,
	bnd_in_if.sink     rx,
	bnd_out_if.source  tx,
	bnd_cfg_if.sink    cfg
);

	localparam int SCW = $clog2(SENTENCE_MAX_LEN + 1);
	localparam logic [SCW:0] MAX_LEN = (SCW+1)'(SENTENCE_MAX_LEN);

	// config registers
	logic [7:0]  preamble_q, start_q;
	logic [15:0] poly_q, init_q;
	logic [7:0]  n_preamble, n_start;
	logic [15:0] n_poly, n_init;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance, fire;

	// framer state
	logic        in_frame_q, n_in_frame;
	hunt_t       hunt_q, n_hunt;
	logic [7:0]  ftc_q, n_ftc;
	logic [15:0] pre_crc_q;
	logic [8:0]  fcount_q, n_fcount;
	logic [7:0]  flen_q, n_flen;
	logic [2:0]  fkind_q, n_fkind;
	logic [15:0] crc_q, n_crc;
	logic [7:0]  crch_q, n_crch;

	// sentence state
	smode_t      smode_q, n_smode;
	logic [7:0]  hdr_q [4];
	logic [7:0]  n_hdr [4];
	logic [SCW-1:0] scount_q, n_scount;
	logic [7:0]  prev_q, n_prev;
	logic [3:0]  skind_q, n_skind;

	// result
	logic       tx_valid_q;
	logic [7:0] data_q, plen_q, pidx_q;
	logic [2:0] pev_q, pkind_q, sev_q;
	logic [3:0] skind_out_q;
	logic [2:0] pev, pkind, sev;
	logic [7:0] plen, pidx;
	logic [3:0] skind;

	logic       type_hit, talk_hit;
	logic [2:0] type_idx;
	logic [3:0] talk_idx;
	logic [39:0] hdr_word;
	logic [8:0] len_end;
	logic [1:0] hidx;
	logic [SCW:0] scount_inc;

	// configuration
	assign cfg.ready = 1'b1;

	always_comb begin
		n_preamble = preamble_q;
		n_start = start_q;
		n_poly = poly_q;
		n_init = init_q;
		if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PREAMBLE:    n_preamble = cfg.data[7:0];
				CFG_START_CHAR:  n_start = cfg.data[7:0];
				CFG_CRC_POLY:    n_poly = cfg.data;
				CFG_CRC_INITIAL: n_init = cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RST;
			start_q <= START_CHAR_RST;
			poly_q <= CRC_POLY_RST;
			init_q <= CRC_INIT_RST;
		end else begin
			preamble_q <= n_preamble;
			start_q <= n_start;
			poly_q <= n_poly;
			init_q <= n_init;
		end
	end

	// handshake
	assign advance = !tx_valid_q || tx.ready;
	assign rx.ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (rx.valid && rx.ready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// table compares
	always_comb begin
		type_hit = 1'b0;
		type_idx = '0;
		for (int i = NUM_PKT_TYPES - 1; i >= 0; i--) begin
			if (PKT_TYPES[i] == {ftc_q, byte_s1}) begin
				type_hit = 1'b1;
				type_idx = 3'(i);
			end
		end
	end

	assign hdr_word = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3], byte_s1};

	always_comb begin
		talk_hit = 1'b0;
		talk_idx = '0;
		for (int i = NUM_TALKERS - 1; i >= 0; i--) begin
			if (TALKERS[i] == hdr_word) begin
				talk_hit = 1'b1;
				talk_idx = 4'(i);
			end
		end
	end

	assign len_end = {1'b0, flen_q} + 9'd3;
	assign hidx = 2'(scount_q - SCW'(1));
	assign scount_inc = {1'b0, scount_q} + (SCW+1)'(1);

	// one pass of both framers
	always_comb begin
		n_in_frame = in_frame_q;
		n_hunt = hunt_q;
		n_ftc = ftc_q;
		n_fcount = fcount_q;
		n_flen = flen_q;
		n_fkind = fkind_q;
		n_crc = crc_q;
		n_crch = crch_q;
		n_smode = smode_q;
		n_hdr = hdr_q;
		n_scount = scount_q;
		n_prev = prev_q;
		n_skind = skind_q;
		pev = PEV_NONE;
		pkind = '0;
		plen = '0;
		pidx = '0;
		sev = SEV_NONE;
		skind = '0;

		if (!in_frame_q) begin
			unique case (hunt_q)
				H_SYNC0: begin
					if (byte_s1 == preamble_q) n_hunt = H_SYNC1;
				end
				H_SYNC1: begin
					n_hunt = (byte_s1 == preamble_q) ? H_TYPE1 : H_SYNC0;
				end
				H_TYPE1: begin
					n_ftc = byte_s1;
					n_hunt = H_TYPE2;
				end
				H_TYPE2: begin
					n_hunt = H_SYNC0;
					if (type_hit) begin
						n_in_frame = 1'b1;
						n_fkind = type_idx;
						n_fcount = 9'd2;
						n_crc = crc_feed(pre_crc_q, byte_s1, poly_q);
						pev = PEV_TYPE;
						pkind = type_idx;
					end
				end
				default: n_hunt = H_SYNC0;
			endcase

			unique case (smode_q)
				SM_IDLE: begin
					if (byte_s1 == start_q) begin
						n_smode = SM_HEAD;
						n_scount = SCW'(1);
						n_prev = byte_s1;
					end
				end
				SM_HEAD: begin
					n_scount = scount_inc[SCW-1:0];
					n_prev = byte_s1;
					if (scount_q < SCW'(5)) begin
						n_hdr[hidx] = byte_s1;
					end else begin
						n_smode = SM_IDLE;
						if (talk_hit) begin
							n_smode = SM_BODY;
							n_skind = talk_idx;
							sev = SEV_HEADER;
							skind = talk_idx;
						end
					end
				end
				SM_BODY: begin
					n_scount = scount_inc[SCW-1:0];
					n_prev = byte_s1;
					skind = skind_q;
					if (byte_s1 == CHAR_LF && prev_q == CHAR_CR) begin
						sev = SEV_END;
						n_smode = SM_IDLE;
					end else if (scount_inc >= MAX_LEN) begin
						sev = SEV_ABORT;
						n_smode = SM_IDLE;
					end else begin
						sev = SEV_BYTE;
					end
				end
				default: n_smode = SM_IDLE;
			endcase
		end else begin
			n_fcount = fcount_q + 9'd1;
			pkind = fkind_q;
			if (fcount_q == 9'd2) begin
				n_flen = byte_s1;
				n_crc = crc_feed(crc_q, byte_s1, poly_q);
				pev = PEV_LENGTH;
			end else if (fcount_q < len_end) begin
				n_crc = crc_feed(crc_q, byte_s1, poly_q);
				pev = PEV_PAYLOAD;
				pidx = 8'(fcount_q - 9'd3);
			end else if (fcount_q == len_end) begin
				n_crch = byte_s1;
				pev = PEV_CRC_HI;
			end else begin
				pev = ({crch_q, byte_s1} == crc_q) ? PEV_GOOD : PEV_BAD;
				n_in_frame = 1'b0;
				n_fcount = '0;
			end
			plen = n_flen;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hunt_q <= H_SYNC0;
			ftc_q <= '0;
			fcount_q <= '0;
			flen_q <= '0;
			fkind_q <= '0;
			crc_q <= CRC_INIT_RST;
			crch_q <= '0;
			smode_q <= SM_IDLE;
			scount_q <= '0;
			prev_q <= '0;
			skind_q <= '0;
		end else if (fire) begin
			in_frame_q <= n_in_frame;
			hunt_q <= n_hunt;
			ftc_q <= n_ftc;
			fcount_q <= n_fcount;
			flen_q <= n_flen;
			fkind_q <= n_fkind;
			crc_q <= n_crc;
			crch_q <= n_crch;
			smode_q <= n_smode;
			scount_q <= n_scount;
			prev_q <= n_prev;
			skind_q <= n_skind;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hdr_q <= n_hdr;
		end
	end

	// crc of crc_initial and the first type character, kept current
	always_ff @(posedge clk) begin
		pre_crc_q <= crc_feed(n_init, fire ? n_ftc : ftc_q, n_poly);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else begin
			tx_valid_q <= fire || (tx_valid_q && !tx.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= byte_s1;
			pev_q <= pev;
			pkind_q <= pkind;
			plen_q <= plen;
			pidx_q <= pidx;
			sev_q <= sev;
			skind_out_q <= skind;
		end
	end

	assign tx.valid = tx_valid_q;
	assign tx.data_byte = data_q;
	assign tx.packet_event = pev_q;
	assign tx.packet_kind = pkind_q;
	assign tx.payload_length = plen_q;
	assign tx.payload_index = pidx_q;
	assign tx.sentence_event = sev_q;
	assign tx.sentence_kind = skind_out_q;

	// checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.packet_event == PEV_PAYLOAD |-> tx.payload_index < tx.payload_length)
		else $error("payload index beyond frame length");

	a_no_nmea_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && (tx.packet_event == PEV_LENGTH || tx.packet_event == PEV_PAYLOAD ||
		tx.packet_event == PEV_CRC_HI || tx.packet_event == PEV_GOOD ||
		tx.packet_event == PEV_BAD) |-> tx.sentence_event == SEV_NONE)
		else $error("sentence event on a word inside a frame");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && tx_valid_q)
		else $error("input stalled with a free pipeline");

	a_fire_makes_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> tx_valid_q)
		else $error("processed word lost");

endmodule
